// ===== rtl/bbg_pkg.sv =====
// ----------------------------------------------------------------------------
// bbg_pkg
// Shared types, constants and arithmetic helpers of the 3x3 gray box blur.
// ----------------------------------------------------------------------------
package bbg_pkg;

  // Frame limits and derived widths
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Field widths fixed by the interface
  localparam int IW_W   = 12;
  localparam int IH_W   = 13;
  localparam int PIX_W  = 8;
  localparam int Q_W    = 5;   // floor(gray/9) fits in 5 bits
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register reset values
  localparam logic [IW_W-1:0] IMAGE_WIDTH_RST  = IW_W'(2048);
  localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = IH_W'(2048);

  // Job queue depth
  localparam int JQ_DEPTH = 4;

  // Line store word: {upper, middle}, each floor(gray/9)
  localparam int LS_W = 2 * Q_W;

  // Register indexes (word address)
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  // Result slots an item can produce, in delivery order
  localparam int RES_PREV_ROW_PREV_COL = 0;
  localparam int RES_PREV_ROW_END_COL  = 1;
  localparam int RES_LAST_ROW_PREV_COL = 2;
  localparam int RES_LAST_ROW_END_COL  = 3;
  localparam int NUM_RES               = 4;

  typedef logic [Q_W-1:0] q_t;
  typedef q_t [2:0][2:0]  win_t;

  // Which neighbors exist for one result
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } bound_t;

  // One item's work handed from the front to the back
  typedef struct packed {
    win_t                 win;
    logic [NUM_RES-1:0]   mask;
    bound_t [NUM_RES-1:0] bounds;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic                 fin;
  } job_t;

  // One result item
  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             done;
  } res_t;

  // floor(x/9) for x < 256 via reciprocal 57/512
  function automatic q_t div9(input logic [PIX_W-1:0] x);
    logic [13:0] p;
    p = 14'(x) * 14'd57;
    return p[13:9];
  endfunction

  // floor((r+g+b)/3) via reciprocal 683/2048
  function automatic logic [PIX_W-1:0] gray3(input logic [PIX_W-1:0] r,
                                             input logic [PIX_W-1:0] g,
                                             input logic [PIX_W-1:0] b);
    logic [9:0]  s;
    logic [19:0] p;
    s = 10'(r) + 10'(g) + 10'(b);
    p = 20'(s) * 20'd683;
    return p[18:11];
  endfunction

endpackage

// ===== rtl/bbg_ram.sv =====
// ----------------------------------------------------------------------------
// bbg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read; a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/bbg_front.sv =====
// ----------------------------------------------------------------------------
// bbg_front
// Accepts pixels, converts to gray, tracks position, runs the line store and
// the 3x3 window, and classifies which results each pixel releases.
// ----------------------------------------------------------------------------
module bbg_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bbg_pkg::IW_W-1:0]   image_width_i,
  input  logic [bbg_pkg::IH_W-1:0]   image_height_i,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [bbg_pkg::PIX_W-1:0]  red_i,
  input  logic [bbg_pkg::PIX_W-1:0]  green_i,
  input  logic [bbg_pkg::PIX_W-1:0]  blue_i,
  output logic                       job_push_o,
  output bbg_pkg::job_t              job_o,
  input  logic                       job_ready_i
);

  localparam int COL_W = bbg_pkg::COL_W;
  localparam int ROW_W = bbg_pkg::ROW_W;
  localparam int Q_W   = bbg_pkg::Q_W;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic             eor, lastrow;
  logic             row_ge1, row_ge2, col_ge1, col_ge2, row_in, col_in;
  logic             accept;

  logic                                   s1_valid_q, s1_valid_d;
  bbg_pkg::q_t                            s1_gray_q;
  logic [COL_W-1:0]                       s1_col_q;
  logic [ROW_W-1:0]                       s1_row_q;
  logic [bbg_pkg::NUM_RES-1:0]            s1_mask_q, mask;
  bbg_pkg::bound_t [bbg_pkg::NUM_RES-1:0] s1_bounds_q, bounds;
  logic                                   s1_fin_q;
  logic                                   s1_adv;

  logic                        fwd_q;
  logic [bbg_pkg::LS_W-1:0]    fwd_data_q;
  logic [bbg_pkg::LS_W-1:0]    ram_rdata, ls_word, ls_wdata;
  bbg_pkg::win_t               win_q, win_next;

  // Clamp the frame size to the supported range
  always_comb begin
    if (image_width_i == '0) begin
      wm1 = '0;
    end else if (int'(image_width_i) > bbg_pkg::MAX_WIDTH) begin
      wm1 = COL_W'(bbg_pkg::MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(int'(image_width_i) - 1);
    end
    if (image_height_i == '0) begin
      hm1 = '0;
    end else if (int'(image_height_i) > bbg_pkg::MAX_HEIGHT) begin
      hm1 = ROW_W'(bbg_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(int'(image_height_i) - 1);
    end
  end

  // Classify the incoming pixel by position
  assign eor     = col_q >= wm1;
  assign lastrow = row_q >= hm1;
  assign row_ge1 = row_q != '0;
  assign row_ge2 = row_q >= ROW_W'(2);
  assign col_ge1 = col_q != '0;
  assign col_ge2 = col_q >= COL_W'(2);
  assign row_in  = row_q <= hm1;
  assign col_in  = col_q <= wm1;

  always_comb begin
    mask[bbg_pkg::RES_PREV_ROW_PREV_COL] = row_ge1 && col_ge1;
    mask[bbg_pkg::RES_PREV_ROW_END_COL]  = row_ge1 && eor;
    mask[bbg_pkg::RES_LAST_ROW_PREV_COL] = lastrow && col_ge1;
    mask[bbg_pkg::RES_LAST_ROW_END_COL]  = lastrow && eor;
    bounds[bbg_pkg::RES_PREV_ROW_PREV_COL] = '{top: row_ge2, bot: row_in,
                                               lft: col_ge2, rgt: col_in};
    bounds[bbg_pkg::RES_PREV_ROW_END_COL]  = '{top: row_ge2, bot: row_in,
                                               lft: col_ge1, rgt: 1'b0};
    bounds[bbg_pkg::RES_LAST_ROW_PREV_COL] = '{top: row_ge1, bot: 1'b0,
                                               lft: col_ge2, rgt: col_in};
    bounds[bbg_pkg::RES_LAST_ROW_END_COL]  = '{top: row_ge1, bot: 1'b0,
                                               lft: col_ge1, rgt: 1'b0};
  end

  // Stage one advances once the job queue can take its work
  assign s1_adv = s1_valid_q && (job_ready_i || (s1_mask_q == '0));
  assign full_o = s1_valid_q && !s1_adv;
  assign accept = push_i && !full_o;

  // Advance the raster position on each accepted pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (eor) begin
        col_d = '0;
        row_d = lastrow ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  assign s1_valid_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      win_q      <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        fwd_q <= s1_adv && (s1_col_q == col_q);
      end
      if (s1_adv) begin
        win_q <= win_next;
      end
    end
  end

  // Capture the pixel's work into stage one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_gray_q   <= bbg_pkg::div9(bbg_pkg::gray3(red_i, green_i, blue_i));
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
      s1_mask_q   <= mask;
      s1_bounds_q <= bounds;
      s1_fin_q    <= eor && lastrow;
      fwd_data_q  <= ls_wdata;
    end
  end

  // Line store holds the two previous rows, already divided by nine
  bbg_ram #(
    .WIDTH (bbg_pkg::LS_W),
    .DEPTH (bbg_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (ls_wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // Bypass a word written at the same edge it was read
  assign ls_word  = fwd_q ? fwd_data_q : ram_rdata;
  assign ls_wdata = {ls_word[Q_W-1:0], s1_gray_q};

  // Shift the window one column and load the new right column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win_q[r][1];
      win_next[r][1] = win_q[r][2];
    end
    win_next[0][2] = ls_word[2*Q_W-1:Q_W];
    win_next[1][2] = ls_word[Q_W-1:0];
    win_next[2][2] = s1_gray_q;
  end

  // Hand the pixel's results to the back end
  assign job_push_o = s1_adv && (s1_mask_q != '0);
  assign job_o = '{win: win_next, mask: s1_mask_q, bounds: s1_bounds_q,
                   row: s1_row_q, col: s1_col_q, fin: s1_fin_q};

endmodule

// ===== rtl/bbg_jobq.sv =====
// ----------------------------------------------------------------------------
// bbg_jobq
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module bbg_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bbg_pkg::job_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output bbg_pkg::job_t data_o,
  input  logic          pop_i
);

  localparam int PTR_W = $clog2(bbg_pkg::JQ_DEPTH);
  localparam int CNT_W = $clog2(bbg_pkg::JQ_DEPTH + 1);

  bbg_pkg::job_t    mem_q [bbg_pkg::JQ_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = cnt_q != CNT_W'(bbg_pkg::JQ_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (int'(wr_q) == bbg_pkg::JQ_DEPTH - 1) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (int'(rd_q) == bbg_pkg::JQ_DEPTH - 1) ? '0 : rd_q + PTR_W'(1);
      end
    end
  end

  // Store the job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/bbg_back.sv =====
// ----------------------------------------------------------------------------
// bbg_back
// Expands each job into its results, one filtered pixel per cycle while the
// output buffer has room, and buffers them for the result side.
// ----------------------------------------------------------------------------
module bbg_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  bbg_pkg::job_t               job_i,
  output logic                        job_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [bbg_pkg::PIX_W-1:0]   blurred_gray_o,
  output logic [bbg_pkg::ROW_W-1:0]   out_row_o,
  output logic [bbg_pkg::COL_W-1:0]   out_col_o,
  output logic                        last_of_run_o,
  output logic                        frame_done_o
);

  localparam int NR    = bbg_pkg::NUM_RES;
  localparam int ROW_W = bbg_pkg::ROW_W;
  localparam int COL_W = bbg_pkg::COL_W;

  logic [NR-1:0]   done_q, done_d;
  logic [NR-1:0]   rem, sel;
  logic            issue, last;
  logic            cr_hi, cc_hi;
  bbg_pkg::bound_t bd;
  bbg_pkg::q_t     up [3];
  bbg_pkg::q_t     mid [3];
  bbg_pkg::q_t     dn [3];
  bbg_pkg::q_t     t [9];
  logic [1:0]      ci, li;
  logic [bbg_pkg::PIX_W-1:0] sum;
  bbg_pkg::res_t   res;

  bbg_pkg::res_t ob_q [2];
  logic          ob_wr_q, ob_rd_q;
  logic [1:0]    ob_cnt_q, ob_cnt_d;
  logic          ob_pop;

  // Pick the next result of the head job
  assign rem   = job_i.mask & ~done_q;
  assign sel   = rem & (~rem + NR'(1));
  assign last  = (rem & ~sel) == '0;
  assign issue = job_valid_i && (ob_cnt_q != 2'd2);
  assign job_pop_o = issue && last;

  always_comb begin
    done_d = done_q;
    if (issue) begin
      done_d = last ? '0 : (done_q | sel);
    end
  end

  // Locate the center in the window
  assign cr_hi = sel[bbg_pkg::RES_LAST_ROW_PREV_COL] | sel[bbg_pkg::RES_LAST_ROW_END_COL];
  assign cc_hi = sel[bbg_pkg::RES_PREV_ROW_END_COL]  | sel[bbg_pkg::RES_LAST_ROW_END_COL];
  assign ci    = cc_hi ? 2'd2 : 2'd1;
  assign li    = cc_hi ? 2'd1 : 2'd0;

  always_comb begin
    bd = '0;
    for (int k = 0; k < NR; k++) begin
      if (sel[k]) begin
        bd = bd | job_i.bounds[k];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      up[c]  = cr_hi ? job_i.win[1][c] : job_i.win[0][c];
      mid[c] = cr_hi ? job_i.win[2][c] : job_i.win[1][c];
      dn[c]  = job_i.win[2][c];
    end
  end

  // Select the nine taps with edge replacement
  always_comb begin
    t[4] = mid[ci];
    t[1] = bd.top ? up[ci] : mid[ci];
    t[7] = bd.bot ? dn[ci] : mid[ci];
    if (bd.lft) begin
      t[3] = mid[li];
      t[0] = bd.top ? up[li] : mid[ci];
      t[6] = bd.bot ? dn[li] : mid[ci];
    end else begin
      t[3] = mid[ci];
      t[0] = mid[ci];
      t[6] = t[7];
    end
    if (bd.rgt) begin
      t[5] = mid[2];
      t[2] = bd.top ? up[2] : mid[ci];
      t[8] = bd.bot ? dn[2] : mid[ci];
    end else begin
      t[5] = mid[ci];
      t[2] = mid[ci];
      t[8] = t[7];
    end
  end

  // Sum the nine pre-divided taps
  always_comb begin
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      sum = sum + bbg_pkg::PIX_W'(t[k]);
    end
  end

  always_comb begin
    res.gray = sum;
    res.row  = cr_hi ? job_i.row : job_i.row - ROW_W'(1);
    res.col  = cc_hi ? job_i.col : job_i.col - COL_W'(1);
    res.last = last;
    res.done = last && job_i.fin;
  end

  // Two-entry output buffer
  assign empty  = ob_cnt_q == 2'd0;
  assign ob_pop = pop && !empty;

  always_comb begin
    ob_cnt_d = ob_cnt_q;
    if (issue && !ob_pop) begin
      ob_cnt_d = ob_cnt_q + 2'd1;
    end else if (ob_pop && !issue) begin
      ob_cnt_d = ob_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= '0;
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      done_q   <= done_d;
      ob_cnt_q <= ob_cnt_d;
      if (issue) begin
        ob_wr_q <= ~ob_wr_q;
      end
      if (ob_pop) begin
        ob_rd_q <= ~ob_rd_q;
      end
    end
  end

  // Hold the filtered result
  always_ff @(posedge clk_i) begin
    if (issue) begin
      ob_q[ob_wr_q] <= res;
    end
  end

  assign blurred_gray_o = ob_q[ob_rd_q].gray;
  assign out_row_o      = ob_q[ob_rd_q].row;
  assign out_col_o      = ob_q[ob_rd_q].col;
  assign last_of_run_o  = ob_q[ob_rd_q].last;
  assign frame_done_o   = ob_q[ob_rd_q].done;

endmodule

// ===== rtl/box_blur_3x3_gray.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_gray
// Streaming 3x3 box blur of a gray image built from RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and the result engine filters one pixel per
// cycle while its output buffer has room. A pixel releases the result of the
// pixel one row and one column behind it, and the last pixel of a row also
// releases the last pixel of the row above. The four-entry job queue holds
// that extra result until the first pixel of the next row, which releases
// none, so ordinary rows take one pixel per cycle while results are popped as
// they come. On the frame's last row every pixel but the first releases two
// results and the last pixel four, so there the input runs slower and full
// holds it back. The line store (one dual-port RAM of MAX_WIDTH words) is
// read and written once per pixel. With the queues empty, a result passes
// from stage one through the job queue into the output buffer and onto the
// outputs. Configure the frame size only while the block is idle.
// ----------------------------------------------------------------------------
module box_blur_3x3_gray (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bbg_pkg::ADDR_W-1:0]          paddr,
  input  logic [bbg_pkg::DATA_W-1:0]          pwdata,
  output logic [bbg_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // pixel input
  input  logic                                push,
  output logic                                full,
  input  logic [bbg_pkg::PIX_W-1:0]           red_i,
  input  logic [bbg_pkg::PIX_W-1:0]           green_i,
  input  logic [bbg_pkg::PIX_W-1:0]           blue_i,
  // results
  output logic                                empty,
  input  logic                                pop,
  output logic [bbg_pkg::PIX_W-1:0]           blurred_gray_o,
  output logic [bbg_pkg::ROW_W-1:0]           out_row_o,
  output logic [bbg_pkg::COL_W-1:0]           out_col_o,
  output logic                                last_of_run_o,
  output logic                                frame_done_o
);

  logic [bbg_pkg::IW_W-1:0] image_width_q;
  logic [bbg_pkg::IH_W-1:0] image_height_q;
  logic                     cfg_wr;
  bbg_pkg::reg_idx_e        reg_idx;

  logic          job_push, job_ready, job_valid, job_pop;
  bbg_pkg::job_t job_in, job_head;

  // Decode the register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = bbg_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= bbg_pkg::IMAGE_WIDTH_RST;
      image_height_q <= bbg_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bbg_pkg::REG_IMAGE_WIDTH: begin
          image_width_q <= pwdata[bbg_pkg::IW_W-1:0];
        end
        bbg_pkg::REG_IMAGE_HEIGHT: begin
          image_height_q <= pwdata[bbg_pkg::IH_W-1:0];
        end
        default: begin
          image_width_q <= image_width_q;
        end
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (reg_idx)
      bbg_pkg::REG_IMAGE_WIDTH:  prdata = bbg_pkg::DATA_W'(image_width_q);
      bbg_pkg::REG_IMAGE_HEIGHT: prdata = bbg_pkg::DATA_W'(image_height_q);
      default:                   prdata = '0;
    endcase
  end

  bbg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .push_i         (push),
    .full_o         (full),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .job_push_o     (job_push),
    .job_o          (job_in),
    .job_ready_i    (job_ready)
  );

  bbg_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .ready_o (job_ready),
    .valid_o (job_valid),
    .data_o  (job_head),
    .pop_i   (job_pop)
  );

  bbg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job_head),
    .job_pop_o      (job_pop),
    .empty          (empty),
    .pop            (pop),
    .blurred_gray_o (blurred_gray_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_of_run_o  (last_of_run_o),
    .frame_done_o   (frame_done_o)
  );

endmodule
